@@ rtl/cwg_pkg.sv @@
// Shared constants, codes and the sequencer state type of the colour wheel lookup.
// No dependencies; imported by color_wheel_gradient_lookup and the bench files.
package cwg_pkg;

	localparam int PALETTE_DEPTH = 8;
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
	localparam int COUNT_W       = $clog2(PALETTE_DEPTH + 1);
	localparam int CH_W          = 12;
	localparam int COL_W         = 3 * CH_W;
	localparam int NUM_CH        = 3;
	localparam int CH_IDX_W      = 2;
	localparam int FRAC_W        = 16;
	localparam int STEPS_W       = 11;
	localparam int STEPS_RESET   = 16;
	localparam int SIZE_W        = COUNT_W + STEPS_W;
	localparam int PROD_W        = FRAC_W + SIZE_W;
	localparam int BLEND_W       = STEPS_W + CH_W;
	localparam int DIV_W         = (SIZE_W > BLEND_W) ? SIZE_W : BLEND_W;
	localparam int DIV_CNT_W     = $clog2(DIV_W);

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_TURN   = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SIZE,
		ST_IDX,
		ST_IDX_DIV,
		ST_RD_SRC,
		ST_RD_DST,
		ST_GET_DST,
		ST_MUL,
		ST_CH_DIV,
		ST_ADD,
		ST_DONE
	} cwg_state_t;

endpackage

@@ rtl/cwg_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module cwg_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/color_wheel_gradient_lookup.sv @@
// Colour wheel gradient lookup: palette store, wheel position and blend sequencer.
// Depends on cwg_pkg and cwg_ram.
//
// channel   dir  handshake                   payload
// item      in   item_valid / item_stall     mode, red_in, green_in, blue_in, fraction
// result    out  result_valid / result_stall red_out, green_out, blue_out
// config    in   cfg_we (no wait)            cfg_data -> steps between colours
//
// Add, turn and ignored items are handled in the idle state.
// A lookup runs through the single shared shift-subtract divider: one pass for
// index / steps, one per channel.
// An empty palette gives black.
// arst_n clears the count, wheel position and output valid and loads the steps register
// with 16; the palette RAM is not cleared and is only read below the colour count.
// A finished result waits in the output register under result_stall; the next item is
// taken meanwhile, and a second lookup holds in its last state until the register frees.
module color_wheel_gradient_lookup (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [1:0]                   mode,
	input  logic [cwg_pkg::CH_W-1:0]     red_in,
	input  logic [cwg_pkg::CH_W-1:0]     green_in,
	input  logic [cwg_pkg::CH_W-1:0]     blue_in,
	input  logic [cwg_pkg::FRAC_W-1:0]   fraction,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [cwg_pkg::CH_W-1:0]     red_out,
	output logic [cwg_pkg::CH_W-1:0]     green_out,
	output logic [cwg_pkg::CH_W-1:0]     blue_out,
	input  logic                         cfg_we,
	input  logic [cwg_pkg::STEPS_W-1:0]  cfg_data
);

	import cwg_pkg::*;

	// control state
	cwg_state_t           state_q, state_d;
	logic [COUNT_W-1:0]   count_q;
	logic [FRAC_W-1:0]    wheel_q;
	logic [STEPS_W-1:0]   steps_cfg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CH_IDX_W-1:0]  ch_q;
	logic                 out_valid_q;

	// working registers of one lookup
	logic [FRAC_W-1:0]    pos_q;
	logic [STEPS_W-1:0]   steps_q;
	logic [SIZE_W-1:0]    size_q;
	logic [STEPS_W-1:0]   step_q;
	logic [DIV_W-1:0]     num_q;     // dividend in, quotient out
	logic [STEPS_W-1:0]   rem_q;
	logic [COL_W-1:0]     src_col_q;
	logic [COL_W-1:0]     dst_col_q;
	logic                 neg_q;
	logic [CH_W-1:0]      res_q [NUM_CH];
	logic [CH_W-1:0]      out_red_q, out_green_q, out_blue_q;

	// handshake and sequencer controls
	logic                 item_take;
	logic                 out_load;
	logic                 div_last;
	logic                 pal_we;
	logic [PAL_AW-1:0]    pal_waddr;
	logic [PAL_AW-1:0]    pal_raddr;
	logic [COL_W-1:0]     pal_rdata;

	// datapath
	logic [FRAC_W-1:0]    mul_a;
	logic [SIZE_W-1:0]    mul_b;
	logic [PROD_W-1:0]    mul_p;
	logic [STEPS_W:0]     div_shift;
	logic                 div_ge;
	logic [STEPS_W:0]     div_sub;
	logic [PAL_AW-1:0]    src_idx;
	logic [COUNT_W-1:0]   dst_next;
	logic [PAL_AW-1:0]    dst_idx;
	logic [CH_W-1:0]      src_ch, dst_ch;
	logic [CH_W:0]        diff;
	logic [CH_W-1:0]      diff_mag;
	logic [CH_W-1:0]      blend;

	assign item_take = item_valid && !item_stall;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !result_stall);
	assign div_last  = (cnt_q == DIV_CNT_W'(DIV_W - 1));

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_take && mode == MODE_LOOKUP) begin
					state_d = (count_q == '0) ? ST_DONE : ST_SIZE;
				end
			end
			ST_SIZE:    state_d = ST_IDX;
			ST_IDX:     state_d = ST_IDX_DIV;
			ST_IDX_DIV: state_d = div_last ? ST_RD_SRC : ST_IDX_DIV;
			ST_RD_SRC:  state_d = ST_RD_DST;
			ST_RD_DST:  state_d = ST_GET_DST;
			ST_GET_DST: state_d = ST_MUL;
			ST_MUL:     state_d = ST_CH_DIV;
			ST_CH_DIV:  state_d = div_last ? ST_ADD : ST_CH_DIV;
			ST_ADD:     state_d = (ch_q == CH_IDX_W'(NUM_CH - 1)) ? ST_DONE : ST_MUL;
			ST_DONE:    state_d = out_load ? ST_IDLE : ST_DONE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// ---------------- sequencer: outputs ----------------
	always_comb begin
		item_stall = (state_q != ST_IDLE);
		pal_we     = item_take && (mode == MODE_ADD) && (count_q < COUNT_W'(PALETTE_DEPTH));
		pal_waddr  = count_q[PAL_AW-1:0];
		mul_a      = '0;
		mul_b      = '0;
		pal_raddr  = src_idx;
		case (state_q)
			ST_SIZE: begin
				mul_a = FRAC_W'(count_q);
				mul_b = SIZE_W'(steps_q);
			end
			ST_IDX: begin
				mul_a = pos_q;
				mul_b = size_q;
			end
			ST_MUL: begin
				mul_a = FRAC_W'(step_q);
				mul_b = SIZE_W'(diff_mag);
			end
			ST_RD_DST: pal_raddr = dst_idx;
			default: ;
		endcase
	end

	// ---------------- shared arithmetic ----------------
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// one restoring step of the divider
	assign div_shift = {rem_q, num_q[DIV_W-1]};
	assign div_ge    = (div_shift >= {1'b0, steps_q});
	assign div_sub   = div_shift - {1'b0, steps_q};

	// quotient of index / steps is the source colour, always below the count
	assign src_idx  = num_q[PAL_AW-1:0];
	assign dst_next = COUNT_W'(src_idx) + COUNT_W'(1);
	assign dst_idx  = (dst_next >= count_q) ? '0 : dst_next[PAL_AW-1:0];

	always_comb begin
		case (ch_q)
			2'd0: begin
				src_ch = src_col_q[3*CH_W-1:2*CH_W];
				dst_ch = dst_col_q[3*CH_W-1:2*CH_W];
			end
			2'd1: begin
				src_ch = src_col_q[2*CH_W-1:CH_W];
				dst_ch = dst_col_q[2*CH_W-1:CH_W];
			end
			default: begin
				src_ch = src_col_q[CH_W-1:0];
				dst_ch = dst_col_q[CH_W-1:0];
			end
		endcase
	end

	// signed difference as sign and magnitude; quotient truncates toward zero
	assign diff     = {1'b0, dst_ch} - {1'b0, src_ch};
	assign diff_mag = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
	assign blend    = neg_q ? (src_ch - num_q[CH_W-1:0]) : (src_ch + num_q[CH_W-1:0]);

	// ---------------- palette store ----------------
	cwg_ram #(
		.WIDTH (COL_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_waddr),
		.wdata ({red_in, green_in, blue_in}),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			wheel_q     <= '0;
			steps_cfg_q <= STEPS_W'(STEPS_RESET);
			cnt_q       <= '0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				steps_cfg_q <= cfg_data;
			end
			if (pal_we) begin
				count_q <= count_q + COUNT_W'(1);
			end
			if (item_take && mode == MODE_TURN) begin
				wheel_q <= wheel_q + fraction;
			end
			if (state_q == ST_IDX_DIV || state_q == ST_CH_DIV) begin
				cnt_q <= div_last ? '0 : cnt_q + DIV_CNT_W'(1);
			end
			if (state_q == ST_GET_DST) begin
				ch_q <= '0;
			end else if (state_q == ST_ADD) begin
				ch_q <= ch_q + CH_IDX_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_take && mode == MODE_LOOKUP) begin
					pos_q   <= wheel_q + fraction;
					steps_q <= (steps_cfg_q == '0) ? STEPS_W'(1) : steps_cfg_q;
					for (int i = 0; i < NUM_CH; i++) begin
						res_q[i] <= '0;
					end
				end
			end
			ST_SIZE: size_q <= mul_p[SIZE_W-1:0];
			ST_IDX: begin
				// index is always below size, so no wrap is needed
				num_q <= DIV_W'(mul_p[PROD_W-1:FRAC_W]);
				rem_q <= '0;
			end
			ST_IDX_DIV, ST_CH_DIV: begin
				num_q <= {num_q[DIV_W-2:0], div_ge};
				rem_q <= div_ge ? div_sub[STEPS_W-1:0] : div_shift[STEPS_W-1:0];
			end
			ST_RD_SRC: step_q <= rem_q;
			ST_RD_DST: src_col_q <= pal_rdata;
			ST_GET_DST: dst_col_q <= pal_rdata;
			ST_MUL: begin
				neg_q <= diff[CH_W];
				num_q <= mul_p[DIV_W-1:0];
				rem_q <= '0;
			end
			ST_ADD: res_q[ch_q] <= blend;
			default: ;
		endcase
	end

	// output register: holds a result while the far side stalls
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_red_q   <= res_q[0];
			out_green_q <= res_q[1];
			out_blue_q  <= res_q[2];
		end
	end

	assign result_valid = out_valid_q;
	assign red_out      = out_red_q;
	assign green_out    = out_green_q;
	assign blue_out     = out_blue_q;

endmodule

@@ bench/cwg_colour_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the colour wheel lookup: follows every transaction on the item,
// result and config ports, predicts each looked-up colour and compares it. Needs cwg_pkg.
module cwg_colour_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         item_stall,
	input  logic [1:0]                   mode,
	input  logic [cwg_pkg::CH_W-1:0]     red_in,
	input  logic [cwg_pkg::CH_W-1:0]     green_in,
	input  logic [cwg_pkg::CH_W-1:0]     blue_in,
	input  logic [cwg_pkg::FRAC_W-1:0]   fraction,
	input  logic                         result_valid,
	input  logic                         result_stall,
	input  logic [cwg_pkg::CH_W-1:0]     red_out,
	input  logic [cwg_pkg::CH_W-1:0]     green_out,
	input  logic [cwg_pkg::CH_W-1:0]     blue_out,
	input  logic                         cfg_we,
	input  logic [cwg_pkg::STEPS_W-1:0]  cfg_data,
	output int unsigned                  fail_count,
	output int unsigned                  pending
);
	import cwg_pkg::*;

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	rgb_t               palette [PALETTE_DEPTH];
	logic [COUNT_W-1:0] pal_count;
	logic [FRAC_W-1:0]  wheel_pos;
	logic [STEPS_W-1:0] steps_reg;
	rgb_t               colour_due [$];
	rgb_t               want_c;
	rgb_t               got_c;

	// linear blend, quotient truncated towards zero
	function automatic logic [CH_W-1:0] mix_toward(input logic [CH_W-1:0] from_ch,
		input logic [CH_W-1:0] to_ch, input int step, input int steps);
		int delta;
		int share;
		delta = int'(to_ch) - int'(from_ch);
		share = (step * delta) / steps;
		return CH_W'(int'(from_ch) + share);
	endfunction

	function automatic rgb_t wheel_colour(input logic [FRAC_W-1:0] offset);
		logic [FRAC_W-1:0] pos;
		int unsigned       steps;
		int unsigned       size;
		int unsigned       idx;
		int unsigned       src;
		int unsigned       dst;
		int unsigned       step;
		longint unsigned   scaled;
		rgb_t              c;
		logic [PAL_AW-1:0] src_a;
		logic [PAL_AW-1:0] dst_a;
		if (pal_count == 0)
			return '0;
		steps  = (steps_reg == 0) ? 1 : steps_reg;
		pos    = wheel_pos + offset;
		size   = pal_count * steps;
		scaled = 64'(pos) * 64'(size);
		idx    = 32'(scaled >> FRAC_W) % size;
		src    = idx / steps;
		if (src >= pal_count)
			src = 0;
		dst = src + 1;
		if (dst >= pal_count)
			dst = 0;
		step    = idx % steps;
		src_a   = PAL_AW'(src);
		dst_a   = PAL_AW'(dst);
		c.red   = mix_toward(palette[src_a].red,   palette[dst_a].red,   step, steps);
		c.green = mix_toward(palette[src_a].green, palette[dst_a].green, step, steps);
		c.blue  = mix_toward(palette[src_a].blue,  palette[dst_a].blue,  step, steps);
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_count  = '0;
			wheel_pos  = '0;
			steps_reg  = STEPS_W'(STEPS_RESET);
			fail_count = 0;
			colour_due.delete();
			pending    = 0;
		end else begin
			if (cfg_we)
				steps_reg = cfg_data;
			if (item_valid && !item_stall) begin
				case (mode)
					MODE_ADD: begin
						if (pal_count < PALETTE_DEPTH) begin
							palette[pal_count[PAL_AW-1:0]] = {red_in, green_in, blue_in};
							pal_count++;
						end
					end
					MODE_TURN:   wheel_pos = wheel_pos + fraction;
					MODE_LOOKUP: colour_due.push_back(wheel_colour(fraction));
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				got_c = {red_out, green_out, blue_out};
				if (colour_due.size() == 0) begin
					if (fail_count < MAX_REPORTS)
						$display("%0t: colour r=%h g=%h b=%h returned with none outstanding",
							$time, got_c.red, got_c.green, got_c.blue);
					fail_count++;
				end else begin
					want_c = colour_due.pop_front();
					if (want_c.red !== got_c.red || want_c.green !== got_c.green ||
						want_c.blue !== got_c.blue) begin
						if (fail_count < MAX_REPORTS)
							$display("%0t: colour mismatch, expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
								$time, want_c.red, want_c.green, want_c.blue,
								got_c.red, got_c.green, got_c.blue);
						fail_count++;
					end
				end
			end
			pending = colour_due.size();
		end
	end

endmodule

@@ bench/tb_color_wheel_gradient_lookup.sv @@
`timescale 1ns / 100ps
// Top of the colour wheel lookup bench: clock, reset, item and config stimulus,
// result back-pressure, watchdog and verdict. Needs cwg_pkg, the block and cwg_colour_checker.
module tb_color_wheel_gradient_lookup;
	import cwg_pkg::*;

	// spare mode code: the block takes the transaction and does nothing with it
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// one lookup through the shared divider, plus margin; used as the settle time
	// before a register write and at the end of the run
	localparam int LOOKUP_CYCLES   = 6 + 3 * (DIV_W + 2) + DIV_W;
	localparam int SETTLE_CYCLES   = LOOKUP_CYCLES + 16;
	// longest correct stretch without a transaction is the long hold-off plus a
	// lookup; the limit is taken well above that
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int STALL_LIMIT     = 5000;
	localparam int N_PHASES        = 8;
	localparam int PHASE_ITEMS     = 228;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	logic [1:0]          mode         = MODE_SPARE;
	logic [CH_W-1:0]     red_in       = '0;
	logic [CH_W-1:0]     green_in     = '0;
	logic [CH_W-1:0]     blue_in      = '0;
	logic [FRAC_W-1:0]   fraction     = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [CH_W-1:0]     red_out;
	logic [CH_W-1:0]     green_out;
	logic [CH_W-1:0]     blue_out;
	logic                cfg_we       = 1'b0;
	logic [STEPS_W-1:0]  cfg_data     = STEPS_W'(STEPS_RESET);

	int unsigned fail_count;
	int unsigned pending;

	// quiet: no idling on either side; hold_off_req: ask the receiver for the long stall
	bit          quiet        = 1'b0;
	bit          hold_off_req = 1'b0;
	int unsigned idle_cycles  = 0;
	int unsigned step_plan [N_PHASES];

	color_wheel_gradient_lookup dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.fraction     (fraction),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	cwg_colour_checker u_colour_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.fraction     (fraction),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// 10 ns clock, rising edges at 5, 15, 25 ...
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: any accepted transaction on either channel resets the count.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side. Random stall bursts, none once quiet is set.
	// On request, one long hold-off counted here so that a finished colour sits in
	// the output register, a second lookup backs up behind it and the item port stalls.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				result_stall <= 1'b0;
				hold_off_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Present one transaction at a falling edge, possibly after an idle burst, and
	// hold it until the rising edge at which the block takes it.
	task automatic offer_item(input logic [1:0] m, input logic [CH_W-1:0] r,
		input logic [CH_W-1:0] g, input logic [CH_W-1:0] b, input logic [FRAC_W-1:0] f);
		int gap;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 16);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		mode       <= m;
		red_in     <= r;
		green_in   <= g;
		blue_in    <= b;
		fraction   <= f;
		do
			@(posedge clk);
		while (item_stall);
	endtask

	// Turn and lookup amounts: weighted towards the ends and the middle of the turn and small steps.
	function automatic logic [FRAC_W-1:0] any_fraction();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return FRAC_W'($urandom_range(1, 255));
			3:       return FRAC_W'(16'h8000 + $urandom_range(0, 3) - 2);
			default: return FRAC_W'($urandom);
		endcase
	endfunction

	// Register writes only with the block idle: every colour back, then a full
	// lookup time in case an add or turn is still being finished.
	task automatic program_steps(input int unsigned steps);
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= STEPS_W'(steps);
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	initial begin
		int unsigned done;
		int unsigned sel;

		// steps per phase: smallest, largest, zero (acts as one), half of the range, three random
		// in 2..1023, and a small value for the quiet final phase
		step_plan = '{1, 2047, 0, 1024, $urandom_range(2, 1023), $urandom_range(2, 1023),
			$urandom_range(2, 1023), 2};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset step count of 16. Lookups on the empty palette
		// give black; the palette then grows one colour at a time with lookups in
		// between, including the one-colour wheel and the wrap of the position.
		offer_item(MODE_LOOKUP, '0, '0, '0, 16'h0000);
		offer_item(MODE_LOOKUP, '1, '1, '1, 16'hFFFF);
		offer_item(MODE_TURN,   '0, '0, '0, 16'hFFFF);
		offer_item(MODE_ADD,    12'h000, 12'h000, 12'h000, 16'hFFFF);
		offer_item(MODE_LOOKUP, '0, '0, '0, 16'h0000);
		offer_item(MODE_ADD,    12'hFFF, 12'hFFF, 12'hFFF, 16'h0000);
		offer_item(MODE_LOOKUP, '0, '0, '0, 16'h0000);
		offer_item(MODE_LOOKUP, '0, '0, '0, 16'h7FFF);
		offer_item(MODE_LOOKUP, '0, '0, '0, 16'h8000);
		offer_item(MODE_TURN,   '1, '1, '1, 16'h0001);
		offer_item(MODE_LOOKUP, '0, '0, '0, 16'hFFFF);
		offer_item(MODE_ADD,    12'hFFF, 12'h000, 12'hAAA, '0);
		offer_item(MODE_ADD,    12'h555, 12'hFFF, 12'h000, '0);
		offer_item(MODE_ADD,    12'h000, 12'hAAA, 12'h555, '0);
		offer_item(MODE_LOOKUP, '0, '0, '0, FRAC_W'($urandom));
		offer_item(MODE_ADD,    12'h800, 12'h7FF, 12'h001, '0);
		offer_item(MODE_ADD,    12'h001, 12'h800, 12'h7FF, '0);
		offer_item(MODE_ADD,    CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), '0);
		offer_item(MODE_ADD,    CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), '0);
		// palette full: this add must change nothing
		offer_item(MODE_ADD,    12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF);
		offer_item(MODE_SPARE,  12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF);
		offer_item(MODE_LOOKUP, '0, '0, '0, 16'h0000);
		offer_item(MODE_LOOKUP, '0, '0, '0, 16'hFFFF);
		offer_item(MODE_TURN,   '0, '0, '0, 16'h8000);
		offer_item(MODE_LOOKUP, '0, '0, '0, FRAC_W'($urandom));

		// Random phases, one step count each. Mostly lookups and turns; adds (now
		// ignored, palette full) and the spare mode are noise.
		for (int p = 0; p < N_PHASES; p++) begin
			program_steps(step_plan[p]);
			quiet = (p == N_PHASES - 1);
			done  = 0;
			while (done < PHASE_ITEMS) begin
				if (p == 1 && done == 20) begin
					// long receiver hold-off while lookups keep coming
					hold_off_req = 1'b1;
					repeat (6) offer_item(MODE_LOOKUP, '0, '0, '0, any_fraction());
				end
				sel = $urandom_range(0, 99);
				if (sel < 50) begin
					offer_item(MODE_LOOKUP, CH_W'($urandom), CH_W'($urandom),
						CH_W'($urandom), any_fraction());
				end else if (sel < 85) begin
					offer_item(MODE_TURN, CH_W'($urandom), CH_W'($urandom),
						CH_W'($urandom), any_fraction());
				end else if (sel < 95) begin
					offer_item(MODE_ADD, CH_W'($urandom), CH_W'($urandom),
						CH_W'($urandom), FRAC_W'($urandom));
				end else begin
					offer_item(MODE_SPARE, CH_W'($urandom), CH_W'($urandom),
						CH_W'($urandom), FRAC_W'($urandom));
				end
				done++;
			end
		end

		// drain: all colours back, then a lookup time for anything stray
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
